/* design/touch_point_to_dial_angle_defines.svh */
// Assertion macros for the touch_point_to_dial_angle design file.
// Define ASSERT_OFF to compile the checks out.
`ifndef TOUCH_POINT_TO_DIAL_ANGLE_DEFINES_SVH
`define TOUCH_POINT_TO_DIAL_ANGLE_DEFINES_SVH

`ifndef ASSERT_OFF
// Same-cycle implication, sampled on clk, off while arst_n is low.
`define TPDA_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication, sampled on clk, off while arst_n is low.
`define TPDA_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define TPDA_ASSERT_NOW(label, ante, cons, msg)
`define TPDA_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

/* design/tpda_pkg.sv */
package tpda_pkg;

	localparam int CENTRE         = 216;
	localparam int NEEDLE_MAX     = 226;
	localparam int RADIUS_MAX     = 511;
	localparam int DEG_FULL       = 360;
	localparam int MIN_RADIUS_RST = 100;

	localparam int CMD_W    = 2;
	localparam int CODE_W   = 2;
	localparam int ANGLE_W  = 9;
	localparam int RADIUS_W = 9;
	localparam int NEEDLE_W = 8;

	// angle accumulator: degrees with a 16-bit fraction
	localparam int FRAC_W    = 16;
	localparam int Z_W       = 26;
	localparam int TABLE_LEN = 24;
	localparam int STEP_W    = 5;

	typedef logic signed [Z_W-1:0] zang_t;

	localparam zang_t Z_QUARTER = zang_t'(90 << FRAC_W);
	localparam zang_t Z_HALF    = zang_t'(180 << FRAC_W);

	typedef enum logic [CMD_W-1:0] {
		CMD_DOWN = 2'd0,
		CMD_UP   = 2'd1,
		CMD_MOVE = 2'd2
	} command_t;

	typedef enum logic [CODE_W-1:0] {
		EV_NONE  = 2'd0,
		EV_GO_TO = 2'd1,
		EV_SET   = 2'd2
	} event_code_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CALC,
		ST_EMIT
	} ctl_state_t;

	typedef enum logic [1:0] {
		RP_IDLE,
		RP_SQUARE,
		RP_ROOT
	} root_phase_t;

	// atan(2^-i) in degrees, 16-bit fraction, rounded
	function automatic zang_t atan_deg(input logic [STEP_W-1:0] idx);
		zang_t v;
		case (idx)
			5'd0: v = zang_t'(2949120);
			5'd1: v = zang_t'(1740967);
			5'd2: v = zang_t'(919879);
			5'd3: v = zang_t'(466945);
			5'd4: v = zang_t'(234379);
			5'd5: v = zang_t'(117304);
			5'd6: v = zang_t'(58666);
			5'd7: v = zang_t'(29335);
			5'd8: v = zang_t'(14668);
			5'd9: v = zang_t'(7334);
			5'd10: v = zang_t'(3667);
			5'd11: v = zang_t'(1833);
			5'd12: v = zang_t'(917);
			5'd13: v = zang_t'(458);
			5'd14: v = zang_t'(229);
			5'd15: v = zang_t'(115);
			5'd16: v = zang_t'(57);
			5'd17: v = zang_t'(29);
			5'd18: v = zang_t'(14);
			5'd19: v = zang_t'(7);
			5'd20: v = zang_t'(4);
			5'd21: v = zang_t'(2);
			5'd22: v = zang_t'(1);
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage

/* design/tpda_cordic.sv */
// Iterative vectoring CORDIC: one micro-rotation per cycle, then a final
// conversion step turns the accumulated angle into whole degrees 0..359.
module tpda_cordic #(
	parameter int COORD_BITS   = 9,
	parameter int CORDIC_STEPS = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	input  logic signed [COORD_BITS:0]         dx,
	input  logic signed [COORD_BITS:0]         dy,
	output logic                               busy,
	output logic [tpda_pkg::ANGLE_W-1:0]       angle
);

	localparam int W       = COORD_BITS + tpda_pkg::FRAC_W + 3;
	localparam int N_STEPS = (CORDIC_STEPS > tpda_pkg::TABLE_LEN) ?
		tpda_pkg::TABLE_LEN : CORDIC_STEPS;
	localparam int LAST    = N_STEPS - 1;

	logic signed [W-1:0] x_q, y_q;
	tpda_pkg::zang_t     z_q;
	logic [tpda_pkg::STEP_W-1:0] step_q;
	logic                busy_q, conv_q;
	logic [tpda_pkg::ANGLE_W-1:0] angle_q;

	logic signed [W-1:0] dx_w, dy_w, x_init, y_init, x_n, y_n, xs, ys;
	tpda_pkg::zang_t     z_init, z_n, t_step;
	logic [tpda_pkg::Z_W-1:0] z_mag;
	logic [tpda_pkg::ANGLE_W-1:0] whole, angle_n;

	// pre-rotate into the right half plane
	always_comb begin
		dx_w = W'(dx) <<< tpda_pkg::FRAC_W;
		dy_w = W'(dy) <<< tpda_pkg::FRAC_W;
		if (dy > 0) begin
			x_init = dy_w;
			y_init = -dx_w;
			z_init = tpda_pkg::Z_QUARTER;
		end else if (dy < 0) begin
			x_init = -dy_w;
			y_init = dx_w;
			z_init = -tpda_pkg::Z_QUARTER;
		end else begin
			x_init = '0;
			y_init = '0;
			z_init = (dx < 0) ? tpda_pkg::Z_HALF : '0;
		end
	end

	always_comb begin
		xs     = x_q >>> step_q;
		ys     = y_q >>> step_q;
		t_step = tpda_pkg::atan_deg(step_q);
		x_n    = x_q;
		y_n    = y_q;
		z_n    = z_q;
		if (y_q != '0) begin
			if (!y_q[W-1]) begin
				x_n = x_q + ys;
				y_n = y_q - xs;
				z_n = z_q + t_step;
			end else begin
				x_n = x_q - ys;
				y_n = y_q + xs;
				z_n = z_q - t_step;
			end
		end
	end

	// truncate toward zero, then wrap negatives
	always_comb begin
		z_mag   = z_q[tpda_pkg::Z_W-1] ? -z_q : z_q;
		whole   = z_mag[tpda_pkg::FRAC_W +: tpda_pkg::ANGLE_W];
		angle_n = (z_q[tpda_pkg::Z_W-1] && whole != '0) ?
			tpda_pkg::ANGLE_W'(tpda_pkg::DEG_FULL) - whole : whole;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			conv_q <= 1'b0;
			step_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			conv_q <= 1'b0;
			step_q <= '0;
		end else if (busy_q && !conv_q) begin
			if (step_q == tpda_pkg::STEP_W'(LAST)) begin
				conv_q <= 1'b1;
			end else begin
				step_q <= step_q + 1'b1;
			end
		end else if (conv_q) begin
			busy_q <= 1'b0;
			conv_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q <= x_init;
			y_q <= y_init;
			z_q <= z_init;
		end else if (busy_q && !conv_q) begin
			x_q <= x_n;
			y_q <= y_n;
			z_q <= z_n;
		end
		if (conv_q) begin
			angle_q <= angle_n;
		end
	end

	assign busy  = busy_q;
	assign angle = angle_q;

endmodule

/* design/tpda_root.sv */
// Radius: dx^2 + dy^2 by bit-serial shift-and-add, then a restoring
// square root that retires one result bit per cycle.
module tpda_root #(
	parameter int COORD_BITS = 9
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic signed [COORD_BITS:0]    dx,
	input  logic signed [COORD_BITS:0]    dy,
	output logic                          busy,
	output logic [tpda_pkg::RADIUS_W-1:0] radius
);

	localparam int C     = COORD_BITS;
	localparam int MW    = 2 * C;
	localparam int RW    = C + 1;
	localparam int RAD_W = 2 * RW;
	localparam int RMW   = RW + 2;
	localparam int CW    = $clog2(RW + 1);

	tpda_pkg::root_phase_t phase_q, phase_n;
	logic [CW-1:0]    cnt_q;
	logic [C-1:0]     bx_q, by_q;
	logic [MW-1:0]    mx_q, my_q;
	logic [RAD_W-1:0] acc_q;
	logic [RMW-1:0]   rem_q;
	logic [RW-1:0]    root_q;

	logic [C:0]       neg_x, neg_y;
	logic [C-1:0]     adx, ady;
	logic [MW-1:0]    pp_x, pp_y;
	logic [RMW-1:0]   rem_sh, trial, diff;
	logic             fits;

	always_comb begin
		neg_x = -dx;
		neg_y = -dy;
		adx   = dx[C] ? neg_x[C-1:0] : dx[C-1:0];
		ady   = dy[C] ? neg_y[C-1:0] : dy[C-1:0];
		pp_x  = bx_q[0] ? mx_q : '0;
		pp_y  = by_q[0] ? my_q : '0;
		rem_sh = {rem_q[RMW-3:0], acc_q[RAD_W-1 -: 2]};
		trial  = {root_q, 2'b01};
		fits   = rem_sh >= trial;
		diff   = rem_sh - trial;
	end

	always_comb begin
		phase_n = phase_q;
		if (start) begin
			phase_n = tpda_pkg::RP_SQUARE;
		end else begin
			case (phase_q)
				tpda_pkg::RP_IDLE: phase_n = tpda_pkg::RP_IDLE;
				tpda_pkg::RP_SQUARE: begin
					if (cnt_q == CW'(C - 1)) phase_n = tpda_pkg::RP_ROOT;
				end
				tpda_pkg::RP_ROOT: begin
					if (cnt_q == CW'(RW - 1)) phase_n = tpda_pkg::RP_IDLE;
				end
				default: phase_n = tpda_pkg::RP_IDLE;
			endcase
		end
	end

	always_comb begin
		busy   = phase_q != tpda_pkg::RP_IDLE;
		radius = (root_q > RW'(tpda_pkg::RADIUS_MAX)) ?
			tpda_pkg::RADIUS_W'(tpda_pkg::RADIUS_MAX) : root_q[tpda_pkg::RADIUS_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= tpda_pkg::RP_IDLE;
			cnt_q   <= '0;
		end else begin
			phase_q <= phase_n;
			if (start || phase_n != phase_q) begin
				cnt_q <= '0;
			end else if (phase_q != tpda_pkg::RP_IDLE) begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			bx_q   <= adx;
			by_q   <= ady;
			mx_q   <= MW'(adx);
			my_q   <= MW'(ady);
			acc_q  <= '0;
			rem_q  <= '0;
			root_q <= '0;
		end else begin
			case (phase_q)
				tpda_pkg::RP_SQUARE: begin
					acc_q <= acc_q + RAD_W'(pp_x) + RAD_W'(pp_y);
					mx_q  <= mx_q << 1;
					my_q  <= my_q << 1;
					bx_q  <= bx_q >> 1;
					by_q  <= by_q >> 1;
				end
				tpda_pkg::RP_ROOT: begin
					acc_q  <= acc_q << 2;
					rem_q  <= fits ? diff : rem_sh;
					root_q <= {root_q[RW-2:0], fits};
				end
				default: begin
					acc_q <= acc_q;
				end
			endcase
		end
	end

endmodule

/* design/touch_point_to_dial_angle.sv */
// A request that computes starts the CORDIC and the bit-serial square and root together;
//   its result goes to the output slot once both are done; other requests go there directly.
// No new request is taken until the last result is in the output slot, so for computing
//   requests the slower unit (the square and root, with the defaults) sets the rate.
// Reset (arst_n low, asynchronous): min_radius = 100, last point and held values zero,
//   no result pending.
`include "touch_point_to_dial_angle_defines.svh"

module touch_point_to_dial_angle #(
	parameter int COORD_BITS   = 9,
	parameter int CORDIC_STEPS = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// min_radius register
	input  logic                                 cfg_we,
	input  logic [tpda_pkg::RADIUS_W-1:0]        cfg_wdata,
	// touch request
	input  logic                                 s_axis_tvalid,
	output logic                                 s_axis_tready,
	// [COORD_BITS-1:0] x_pos, [2*COORD_BITS-1:COORD_BITS] y_pos, rest zero
	input  logic [((2*COORD_BITS+7)/8)*8-1:0]    s_axis_tdata,
	// [1:0] command
	input  logic [tpda_pkg::CMD_W-1:0]           s_axis_tuser,
	// dial result
	output logic                                 m_axis_tvalid,
	input  logic                                 m_axis_tready,
	// [8:0] touch_angle, [17:9] touch_radius, [25:18] needle_angle, [31:26] zero
	output logic [31:0]                          m_axis_tdata,
	// [1:0] event_code
	output logic [tpda_pkg::CODE_W-1:0]          m_axis_tuser
);

	localparam int C      = COORD_BITS;

	// control state
	tpda_pkg::ctl_state_t  state_q, state_n;
	tpda_pkg::event_code_t kind_q, kind_n;
	logic [tpda_pkg::RADIUS_W-1:0] min_radius_q;
	logic [C-1:0]                  last_x_q, last_y_q;
	logic [tpda_pkg::ANGLE_W-1:0]  held_angle_q;
	logic [tpda_pkg::RADIUS_W-1:0] held_radius_q;
	logic                          out_valid_q;

	// output slot payload
	tpda_pkg::event_code_t         out_code_q;
	logic [tpda_pkg::ANGLE_W-1:0]  out_angle_q;
	logic [tpda_pkg::RADIUS_W-1:0] out_radius_q;
	logic [tpda_pkg::NEEDLE_W-1:0] out_needle_q;

	logic                  accept, go, start, calc_done, slot_free, load;
	tpda_pkg::command_t    cmd;
	logic [C-1:0]          px, py;
	logic signed [C:0]     dx, dy;
	logic                  cordic_busy, root_busy;
	logic [tpda_pkg::ANGLE_W-1:0]  cordic_angle, needle_full;
	logic [tpda_pkg::RADIUS_W-1:0] root_radius;
	tpda_pkg::event_code_t code_n;
	logic [tpda_pkg::NEEDLE_W-1:0] needle_n;

	// Decode the incoming request. Down and up always recompute; a move
	// recomputes only when the point has changed; anything else just
	// reports the held values with no event.
	always_comb begin
		px  = s_axis_tdata[C-1:0];
		py  = s_axis_tdata[2*C-1:C];
		cmd = tpda_pkg::command_t'(s_axis_tuser);
		dx  = $signed({1'b0, px}) - (C+1)'(tpda_pkg::CENTRE);
		dy  = (C+1)'(tpda_pkg::CENTRE) - $signed({1'b0, py});
		case (cmd)
			tpda_pkg::CMD_DOWN, tpda_pkg::CMD_UP: begin
				go     = 1'b1;
				kind_n = tpda_pkg::EV_GO_TO;
			end
			tpda_pkg::CMD_MOVE: begin
				go     = (px != last_x_q) || (py != last_y_q);
				kind_n = go ? tpda_pkg::EV_SET : tpda_pkg::EV_NONE;
			end
			default: begin
				go     = 1'b0;
				kind_n = tpda_pkg::EV_NONE;
			end
		endcase
	end

	// Angle and radius run side by side from the same start pulse.
	tpda_cordic #(
		.COORD_BITS  (COORD_BITS),
		.CORDIC_STEPS(CORDIC_STEPS)
	) u_cordic (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.dx    (dx),
		.dy    (dy),
		.busy  (cordic_busy),
		.angle (cordic_angle)
	);

	tpda_root #(
		.COORD_BITS(COORD_BITS)
	) u_root (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.dx    (dx),
		.dy    (dy),
		.busy  (root_busy),
		.radius(root_radius)
	);

	// next state
	always_comb begin
		state_n = state_q;
		case (state_q)
			tpda_pkg::ST_IDLE: begin
				if (accept) state_n = go ? tpda_pkg::ST_CALC : tpda_pkg::ST_EMIT;
			end
			tpda_pkg::ST_CALC: begin
				if (calc_done) state_n = tpda_pkg::ST_EMIT;
			end
			tpda_pkg::ST_EMIT: begin
				if (slot_free) state_n = tpda_pkg::ST_IDLE;
			end
			default: state_n = tpda_pkg::ST_IDLE;
		endcase
	end

	// handshake and strobes; the output slot decouples the two sides, so a
	// new request is taken while the previous result still waits
	always_comb begin
		s_axis_tready = state_q == tpda_pkg::ST_IDLE;
		accept        = s_axis_tvalid && s_axis_tready;
		start         = accept && go;
		calc_done     = (state_q == tpda_pkg::ST_CALC) && !cordic_busy && !root_busy;
		slot_free     = !out_valid_q || m_axis_tready;
		load          = (state_q == tpda_pkg::ST_EMIT) && slot_free;
	end

	// result fields from the held values
	always_comb begin
		code_n = ((kind_q != tpda_pkg::EV_NONE) && (held_radius_q > min_radius_q)) ?
			kind_q : tpda_pkg::EV_NONE;
		needle_full = (held_angle_q > tpda_pkg::ANGLE_W'(tpda_pkg::NEEDLE_MAX)) ?
			tpda_pkg::ANGLE_W'(tpda_pkg::NEEDLE_MAX) : held_angle_q;
		needle_n = {needle_full[tpda_pkg::NEEDLE_W-1:1], 1'b0};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= tpda_pkg::ST_IDLE;
			kind_q        <= tpda_pkg::EV_NONE;
			min_radius_q  <= tpda_pkg::RADIUS_W'(tpda_pkg::MIN_RADIUS_RST);
			last_x_q      <= '0;
			last_y_q      <= '0;
			held_angle_q  <= '0;
			held_radius_q <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			state_q <= state_n;
			if (cfg_we) begin
				min_radius_q <= cfg_wdata;
			end
			if (accept) begin
				kind_q <= kind_n;
			end
			// advance the last point as soon as the request commits
			if (start) begin
				last_x_q <= px;
				last_y_q <= py;
			end
			if (calc_done) begin
				held_angle_q  <= cordic_angle;
				held_radius_q <= root_radius;
			end
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// output slot: hold while the consumer stalls
	always_ff @(posedge clk) begin
		if (load) begin
			out_code_q   <= code_n;
			out_angle_q  <= held_angle_q;
			out_radius_q <= held_radius_q;
			out_needle_q <= needle_n;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = out_code_q;
	assign m_axis_tdata  = 32'({out_needle_q, out_radius_q, out_angle_q});

	`TPDA_ASSERT_NOW(a_ready_units_idle, s_axis_tready, !cordic_busy && !root_busy, "request taken while a unit is busy")
	`TPDA_ASSERT_NEXT(a_start_busy, start, cordic_busy && root_busy, "unit did not start")
	`TPDA_ASSERT_NEXT(a_load_valid, load, m_axis_tvalid, "loaded result not presented")
	`TPDA_ASSERT_NOW(a_code_radius, m_axis_tvalid && (out_code_q != tpda_pkg::EV_NONE), out_radius_q > min_radius_q, "event without radius")
	`TPDA_ASSERT_NOW(a_angle_range, m_axis_tvalid, out_angle_q < tpda_pkg::ANGLE_W'(tpda_pkg::DEG_FULL), "angle out of range")

endmodule
